>>> rtl/core/nwsr_pkg.sv
// Package for the nibble wildcard search and replace core.
// Holds the window size, register index codes, payload and control structs.
// No dependencies; every core file refers to it by scoped names.
`timescale 1ns / 1ps
`default_nettype none

package nwsr_pkg;

   localparam int WINDOW_BYTES = 8;
   // The pattern registers hold eight byte lanes.
   localparam int PAT_BYTES = 8;
   localparam int CMP_BYTES = (WINDOW_BYTES < PAT_BYTES) ? WINDOW_BYTES : PAT_BYTES;
   localparam int CNT_W = $clog2(WINDOW_BYTES + 1);
   localparam int LEN_W = (CNT_W > 4) ? CNT_W : 4;
   localparam int IDX_W = $clog2(WINDOW_BYTES);
   localparam int CSR_INDEX_W = 8;
   localparam logic [31:0] INDEX_MAX = 32'hFFFF_FFFF;

   typedef logic [CNT_W-1:0] cnt_type;
   typedef logic [LEN_W-1:0] len_type;
   typedef logic [IDX_W-1:0] pos_type;
   typedef logic [WINDOW_BYTES-1:0][7:0] window_type;

   typedef enum logic [CSR_INDEX_W-1:0] {
      REG_SEARCH_VALUE  = 8'd0,
      REG_SEARCH_CARE   = 8'd1,
      REG_SEARCH_LEN    = 8'd2,
      REG_REPLACE_VALUE = 8'd3,
      REG_REPLACE_CARE  = 8'd4,
      REG_REPLACE_LEN   = 8'd5,
      REG_FIRST_ONLY    = 8'd6
   } csr_index_type;

   typedef struct packed {
      logic [63:0] search_value;
      logic [63:0] search_care;
      logic [3:0]  search_len;
      logic [63:0] replace_value;
      logic [63:0] replace_care;
      logic [3:0]  replace_len;
      logic        first_only;
   } csr_type;

   typedef struct packed {
      logic [7:0] data_byte;
      logic       stream_end;
   } req_payload_type;

   typedef struct packed {
      logic [7:0]  out_byte;
      logic        match_here;
      logic [31:0] byte_index;
      logic        end_out;
   } rsp_payload_type;

   typedef struct packed {
      cnt_type avail;
      logic    blocked;
   } emit_ctrl_type;

   typedef struct packed {
      logic       hit;
      window_type window;
   } emit_result_type;

   // Lengths above what the window and the pattern lanes can hold saturate.
   function automatic len_type cap_len(input logic [3:0] len);
      len_type ext;
      ext = len_type'(len);
      return (ext > len_type'(CMP_BYTES)) ? len_type'(CMP_BYTES) : ext;
   endfunction

endpackage

`default_nettype wire

>>> rtl/core/nwsr_emit.sv
// Compare and patch logic for the oldest window position.
// Depends on nwsr_pkg for the window, register and control structs.
`timescale 1ns / 1ps
`default_nettype none

module nwsr_emit (
   input  nwsr_pkg::csr_type         csr,
   input  nwsr_pkg::window_type      win_in,
   input  nwsr_pkg::emit_ctrl_type   ctrl,
   output nwsr_pkg::emit_result_type result
);

   nwsr_pkg::len_type slen;
   nwsr_pkg::len_type rlen_cap;
   nwsr_pkg::len_type rlen;
   nwsr_pkg::len_type avail_ext;
   logic              hit;

   assign slen      = nwsr_pkg::cap_len(csr.search_len);
   assign rlen_cap  = nwsr_pkg::cap_len(csr.replace_len);
   assign avail_ext = nwsr_pkg::len_type'(ctrl.avail);
   // A replacement never runs past the last byte still pending in the stream.
   assign rlen      = (rlen_cap > avail_ext) ? avail_ext : rlen_cap;

   always_comb begin
      hit = (slen != '0) && (slen <= avail_ext) && !ctrl.blocked;
      for (int k = 0; k < nwsr_pkg::CMP_BYTES; k++) begin
         if ((nwsr_pkg::len_type'(k) < slen) &&
             (((win_in[k] ^ csr.search_value[8*k +: 8]) & csr.search_care[8*k +: 8]) != 8'h00))
         begin
            hit = 1'b0;
         end
      end
   end

   always_comb begin
      result.hit    = hit;
      result.window = win_in;
      for (int k = 0; k < nwsr_pkg::CMP_BYTES; k++) begin
         if (hit && (nwsr_pkg::len_type'(k) < rlen)) begin
            result.window[k] = (win_in[k] & ~csr.replace_care[8*k +: 8]) |
                               (csr.replace_value[8*k +: 8] & csr.replace_care[8*k +: 8]);
         end
      end
   end

endmodule

`default_nettype wire

>>> rtl/core/nibble_wildcard_search_replace_core.sv
// Top level of the nibble wildcard search and replace core.
// Depends on nwsr_pkg and instantiates nwsr_emit.
`timescale 1ns / 1ps
`default_nettype none

// Bytes enter on the req_ channel and wait in a window of WINDOW_BYTES registers. Once the
// window is full, one byte leaves per cycle unless stalled: it is checked against the
// search pattern, the window is patched on a match, and the byte goes out on the rsp_
// channel with its match flag and stream offset. In a running stream the core takes one
// byte per cycle unless stalled. Once the window is full, a byte is taken only in a cycle
// in which the oldest byte can move into the result register, so a result that the
// receiver holds back also stalls the input. A transaction with stream_end set starts a
// flush: every pending byte (up to WINDOW_BYTES) is sent, one per cycle unless stalled,
// and req_ready stays low until the last one has gone into the result register. Compare,
// patch and shift of the window are combinational, so the patch feedback loop through the
// window sets the rate.
// The csr_ port is always ready; registers may be written only while the core is idle.
module nibble_wildcard_search_replace_core (
   input  wire                                       clock,
   input  wire                                       reset,
   input  wire                                       req_valid,
   output logic                                      req_ready,
   input  nwsr_pkg::req_payload_type                 req_data,
   output logic                                      rsp_valid,
   input  wire                                       rsp_ready,
   output nwsr_pkg::rsp_payload_type                 rsp_data,
   input  wire                                       csr_valid,
   output logic                                      csr_ready,
   input  wire  [nwsr_pkg::CSR_INDEX_W-1:0]          csr_index,
   input  wire  [63:0]                               csr_wdata
);

   nwsr_pkg::csr_type          csr_ff, csr_in;
   nwsr_pkg::window_type       win_ff, win_in;
   nwsr_pkg::window_type       win_shift;
   nwsr_pkg::cnt_type          fill_ff, fill_in;
   nwsr_pkg::cnt_type          wr_cnt;
   logic                       flushing_ff, flushing_in;
   logic                       match_seen_ff, match_seen_in;
   logic [31:0]                index_ff, index_in;
   logic                       rsp_valid_ff, rsp_valid_in;
   nwsr_pkg::rsp_payload_type  rsp_data_ff, rsp_data_in;

   nwsr_pkg::emit_ctrl_type    emit_ctrl;
   nwsr_pkg::emit_result_type  emit_res;

   logic full;
   logic emit_due;
   logic out_free;
   logic emit;
   logic last;
   logic accept;

   assign full     = (fill_ff == nwsr_pkg::cnt_type'(nwsr_pkg::WINDOW_BYTES));
   assign emit_due = full || (flushing_ff && (fill_ff != '0));
   assign out_free = !rsp_valid_ff || rsp_ready;
   assign emit     = emit_due && out_free;
   assign last     = flushing_ff && (fill_ff == nwsr_pkg::cnt_type'(1));

   // A full window takes a byte only in a cycle in which its oldest byte leaves.
   assign req_ready = !flushing_ff && (!full || emit);
   assign accept    = req_valid && req_ready;

   assign csr_ready = 1'b1;
   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_data_ff;

   assign emit_ctrl.avail   = fill_ff;
   assign emit_ctrl.blocked = csr_ff.first_only && match_seen_ff;

   nwsr_emit u_emit (
      .csr    (csr_ff),
      .win_in (win_ff),
      .ctrl   (emit_ctrl),
      .result (emit_res)
   );

   always_comb begin
      for (int k = 0; k < nwsr_pkg::WINDOW_BYTES - 1; k++) begin
         win_shift[k] = emit_res.window[k+1];
      end
      win_shift[nwsr_pkg::WINDOW_BYTES-1] = emit_res.window[nwsr_pkg::WINDOW_BYTES-1];
   end

   assign wr_cnt = fill_ff - nwsr_pkg::cnt_type'(emit);

   always_comb begin
      win_in = emit ? win_shift : win_ff;
      if (accept) begin
         win_in[wr_cnt[nwsr_pkg::IDX_W-1:0]] = req_data.data_byte;
      end
   end

   assign fill_in = wr_cnt + nwsr_pkg::cnt_type'(accept);

   always_comb begin
      flushing_in   = flushing_ff;
      match_seen_in = match_seen_ff;
      index_in      = index_ff;
      if (emit && last) begin
         flushing_in   = 1'b0;
         match_seen_in = 1'b0;
         index_in      = '0;
      end else begin
         if (accept && req_data.stream_end) begin
            flushing_in = 1'b1;
         end
         if (emit && emit_res.hit) begin
            match_seen_in = 1'b1;
         end
         if (emit && (index_ff != nwsr_pkg::INDEX_MAX)) begin
            index_in = index_ff + 32'd1;
         end
      end
   end

   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      rsp_data_in  = rsp_data_ff;
      if (emit) begin
         rsp_valid_in           = 1'b1;
         rsp_data_in.out_byte   = emit_res.window[0];
         rsp_data_in.match_here = emit_res.hit;
         rsp_data_in.byte_index = index_ff;
         rsp_data_in.end_out    = last;
      end else if (rsp_ready) begin
         rsp_valid_in = 1'b0;
      end
   end

   always_comb begin
      csr_in = csr_ff;
      if (csr_valid) begin
         unique case (csr_index)
            nwsr_pkg::REG_SEARCH_VALUE:  csr_in.search_value  = csr_wdata;
            nwsr_pkg::REG_SEARCH_CARE:   csr_in.search_care   = csr_wdata;
            nwsr_pkg::REG_SEARCH_LEN:    csr_in.search_len    = csr_wdata[3:0];
            nwsr_pkg::REG_REPLACE_VALUE: csr_in.replace_value = csr_wdata;
            nwsr_pkg::REG_REPLACE_CARE:  csr_in.replace_care  = csr_wdata;
            nwsr_pkg::REG_REPLACE_LEN:   csr_in.replace_len   = csr_wdata[3:0];
            nwsr_pkg::REG_FIRST_ONLY:    csr_in.first_only    = csr_wdata[0];
            default: ;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         csr_ff        <= '0;
         fill_ff       <= '0;
         flushing_ff   <= 1'b0;
         match_seen_ff <= 1'b0;
         index_ff      <= '0;
         rsp_valid_ff  <= 1'b0;
      end else begin
         csr_ff        <= csr_in;
         fill_ff       <= fill_in;
         flushing_ff   <= flushing_in;
         match_seen_ff <= match_seen_in;
         index_ff      <= index_in;
         rsp_valid_ff  <= rsp_valid_in;
      end
   end

   // Window contents and result payload carry no reset.
   always_ff @(posedge clock) begin
      win_ff      <= win_in;
      rsp_data_ff <= rsp_data_in;
   end

`ifndef SYNTHESIS
   a_fill_bound: assert property (@(posedge clock) disable iff (reset)
      fill_ff <= nwsr_pkg::cnt_type'(nwsr_pkg::WINDOW_BYTES))
      else $error("window fill count exceeds the window size");

   a_no_accept_in_flush: assert property (@(posedge clock) disable iff (reset)
      flushing_ff |-> !req_ready)
      else $error("input taken while the window is being flushed");

   a_flush_done: assert property (@(posedge clock) disable iff (reset)
      (emit && last) |=> (fill_ff == '0) && !flushing_ff && (index_ff == '0) && !match_seen_ff)
      else $error("stream state not cleared after the final byte");

   a_index_step: assert property (@(posedge clock) disable iff (reset)
      (emit && !last && (index_ff != nwsr_pkg::INDEX_MAX)) |=>
         (index_ff == $past(index_ff) + 32'd1))
      else $error("byte index did not advance by one");

   a_result_held: assert property (@(posedge clock) disable iff (reset)
      (emit_due && !out_free) |=> (rsp_data_ff == $past(rsp_data_ff)))
      else $error("pending result overwritten while stalled");
`endif

endmodule

`default_nettype wire

>>> bench/nibble_wildcard_search_replace_core_tb.sv
// Self-checking testbench for nibble_wildcard_search_replace_core.
// Depends on nwsr_pkg and the core; a scoreboard class predicts every emitted byte.
`timescale 1ns / 1ps

class search_patch_scoreboard;
   logic [63:0] search_value, search_care, replace_value, replace_care;
   logic [3:0]  search_len, replace_len;
   logic        first_only;

   logic [7:0]  window [nwsr_pkg::WINDOW_BYTES];
   int unsigned fill;
   bit          match_seen;
   logic [31:0] next_index;

   nwsr_pkg::rsp_payload_type expected_bytes[$];
   int unsigned errors, checked, hit_count;

   function new();
      search_value = '0;
      search_care = '0;
      search_len = '0;
      replace_value = '0;
      replace_care = '0;
      replace_len = '0;
      first_only = 1'b0;
      foreach (window[k]) window[k] = 8'h00;
      fill = 0;
      match_seen = 0;
      next_index = '0;
      errors = 0;
      checked = 0;
      hit_count = 0;
   endfunction

   function void set_register(nwsr_pkg::csr_index_type idx, logic [63:0] value);
      case (idx)
         nwsr_pkg::REG_SEARCH_VALUE:  search_value = value;
         nwsr_pkg::REG_SEARCH_CARE:   search_care = value;
         nwsr_pkg::REG_SEARCH_LEN:    search_len = value[3:0];
         nwsr_pkg::REG_REPLACE_VALUE: replace_value = value;
         nwsr_pkg::REG_REPLACE_CARE:  replace_care = value;
         nwsr_pkg::REG_REPLACE_LEN:   replace_len = value[3:0];
         nwsr_pkg::REG_FIRST_ONLY:    first_only = value[0];
         default: ;
      endcase
   endfunction

   function int unsigned clip_len(logic [3:0] len);
      return (len > nwsr_pkg::CMP_BYTES) ? nwsr_pkg::CMP_BYTES : int'(len);
   endfunction

   // Compare at the oldest byte, patch the window on a hit, then shift it out.
   function void emit_oldest(int unsigned avail, bit last);
      int unsigned slen, rlen;
      bit hit;
      logic [7:0] mask;
      nwsr_pkg::rsp_payload_type res;
      slen = clip_len(search_len);
      rlen = clip_len(replace_len);
      hit = 0;
      if (slen > 0 && slen <= avail && !(first_only && match_seen)) begin
         hit = 1;
         for (int k = 0; k < slen; k++)
            if (((window[k] ^ search_value[8*k +: 8]) & search_care[8*k +: 8]) != 8'h00)
               hit = 0;
      end
      if (hit) begin
         match_seen = 1;
         hit_count++;
         if (rlen > avail) rlen = avail;
         for (int k = 0; k < rlen; k++) begin
            mask = replace_care[8*k +: 8];
            window[k] = (window[k] & ~mask) | (replace_value[8*k +: 8] & mask);
         end
      end
      res.out_byte = window[0];
      res.match_here = hit;
      res.byte_index = next_index;
      res.end_out = last;
      expected_bytes = {expected_bytes, res};
      if (next_index != 32'hFFFF_FFFF) next_index++;
      for (int k = 1; k < avail && k < nwsr_pkg::WINDOW_BYTES; k++)
         window[k-1] = window[k];
      if (fill > 0) fill--;
   endfunction

   function void note_request(nwsr_pkg::req_payload_type item);
      if (fill < nwsr_pkg::WINDOW_BYTES) begin
         window[fill] = item.data_byte;
         fill++;
      end
      if (item.stream_end) begin
         while (fill > 0) emit_oldest(fill, fill == 1);
         match_seen = 0;
         next_index = '0;
      end else if (fill >= nwsr_pkg::WINDOW_BYTES) begin
         emit_oldest(fill, 0);
      end
   endfunction

   task report(string msg);
      errors++;
      // Keep the log readable when something is badly broken.
      if (errors <= 40) $display("MISMATCH: %s", msg);
   endtask

   task check_response(nwsr_pkg::rsp_payload_type got);
      nwsr_pkg::rsp_payload_type want;
      if (expected_bytes.size() == 0) begin
         report($sformatf("result with nothing expected: byte %02h index %0d",
                          got.out_byte, got.byte_index));
         return;
      end
      want = expected_bytes.pop_front();
      checked++;
      if (got.out_byte !== want.out_byte)
         report($sformatf("index %0d: out_byte %02h, expected %02h",
                          want.byte_index, got.out_byte, want.out_byte));
      if (got.match_here !== want.match_here)
         report($sformatf("index %0d: match_here %b, expected %b",
                          want.byte_index, got.match_here, want.match_here));
      if (got.byte_index !== want.byte_index)
         report($sformatf("byte_index %0d, expected %0d", got.byte_index, want.byte_index));
      if (got.end_out !== want.end_out)
         report($sformatf("index %0d: end_out %b, expected %b",
                          want.byte_index, got.end_out, want.end_out));
   endtask
endclass

module nibble_wildcard_search_replace_core_tb;

   typedef logic [7:0] byte_queue_type [$];

   localparam int unsigned LIMIT_CYCLES = 400000;
   localparam int unsigned SETTLE_CYCLES = 2 * nwsr_pkg::WINDOW_BYTES;
   localparam int unsigned RANDOM_ITEMS = 500;

   logic clock = 1'b0;
   logic reset = 1'b1;
   logic req_valid = 1'b0;
   logic req_ready;
   nwsr_pkg::req_payload_type req_data = '0;
   logic rsp_valid;
   logic rsp_ready = 1'b0;
   nwsr_pkg::rsp_payload_type rsp_data;
   logic csr_valid = 1'b0;
   logic csr_ready;
   logic [nwsr_pkg::CSR_INDEX_W-1:0] csr_index = '0;
   logic [63:0] csr_wdata = '0;

   search_patch_scoreboard patcher = new();

   int unsigned send_gap_pct = 0;
   int unsigned stall_pct = 0;
   int unsigned items_sent = 0;
   int unsigned streams_sent = 0;
   int unsigned settings_used = 0;
   int unsigned cycle_count = 0;

   nibble_wildcard_search_replace_core DUT (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_ready (req_ready),
      .req_data  (req_data),
      .rsp_valid (rsp_valid),
      .rsp_ready (rsp_ready),
      .rsp_data  (rsp_data),
      .csr_valid (csr_valid),
      .csr_ready (csr_ready),
      .csr_index (csr_index),
      .csr_wdata (csr_wdata)
   );

   initial begin
      forever #4 clock = ~clock;
   end

   always @(posedge clock) begin
      cycle_count++;
      if (cycle_count > LIMIT_CYCLES) begin
         $display("timeout after %0d cycles, %0d results outstanding",
                  cycle_count, patcher.expected_bytes.size());
         $display("nibble_wildcard_search_replace_core_tb: errors");
         $finish;
      end
   end

   always @(negedge clock) begin
      rsp_ready <= ($urandom_range(99) >= stall_pct);
   end

   // Capture at the rising edge and check at the falling edge, so that the
   // prediction for a transaction accepted at the same edge is in place.
   always begin : response_monitor
      nwsr_pkg::rsp_payload_type seen;
      @(posedge clock);
      if (!reset && rsp_valid && rsp_ready) begin
         seen = rsp_data;
         @(negedge clock);
         patcher.check_response(seen);
      end
   end

   task automatic send_item(input nwsr_pkg::req_payload_type item);
      while ($urandom_range(99) < send_gap_pct) begin
         req_valid <= 1'b0;
         @(negedge clock);
      end
      req_valid <= 1'b1;
      req_data <= item;
      @(posedge clock);
      while (!req_ready) @(posedge clock);
      patcher.note_request(item);
      items_sent++;
      @(negedge clock);
   endtask

   task automatic send_stream(input byte_queue_type bytes);
      nwsr_pkg::req_payload_type item;
      for (int i = 0; i < bytes.size(); i++) begin
         item.data_byte = bytes[i];
         item.stream_end = (i == bytes.size() - 1);
         send_item(item);
      end
      streams_sent++;
   endtask

   task automatic write_reg(input nwsr_pkg::csr_index_type idx, input logic [63:0] value);
      csr_valid <= 1'b1;
      csr_index <= idx;
      csr_wdata <= value;
      @(posedge clock);
      while (!csr_ready) @(posedge clock);
      patcher.set_register(idx, value);
      @(negedge clock);
   endtask

   task automatic write_all(input logic [63:0] sv, input logic [63:0] sc, input logic [3:0] sl,
                            input logic [63:0] rv, input logic [63:0] rc, input logic [3:0] rl,
                            input logic fo);
      write_reg(nwsr_pkg::REG_SEARCH_VALUE, sv);
      write_reg(nwsr_pkg::REG_SEARCH_CARE, sc);
      write_reg(nwsr_pkg::REG_SEARCH_LEN, {60'd0, sl});
      write_reg(nwsr_pkg::REG_REPLACE_VALUE, rv);
      write_reg(nwsr_pkg::REG_REPLACE_CARE, rc);
      write_reg(nwsr_pkg::REG_REPLACE_LEN, {60'd0, rl});
      write_reg(nwsr_pkg::REG_FIRST_ONLY, {63'd0, fo});
      csr_valid <= 1'b0;
      settings_used++;
   endtask

   // Wait for every predicted byte, then give the core time to go idle.
   task automatic drain();
      req_valid <= 1'b0;
      while (patcher.expected_bytes.size() != 0) @(negedge clock);
      repeat (SETTLE_CYCLES) @(negedge clock);
   endtask

   function automatic logic [63:0] random_word();
      return {$urandom, $urandom};
   endfunction

   function automatic logic [63:0] random_mask();
      case ($urandom_range(0, 3))
         0: return '1;
         1: return '0;
         2: return random_word();
         default: return random_word() | random_word();
      endcase
   endfunction

   function automatic logic [3:0] random_len();
      int unsigned r;
      r = $urandom_range(0, 11);
      return (r <= 8) ? 4'(r) : 4'($urandom_range(9, 15));
   endfunction

   // Most streams carry planted pattern copies with random wildcard nibbles.
   function automatic byte_queue_type make_stream(int unsigned len, bit planted);
      byte_queue_type bytes;
      int unsigned slen;
      logic [7:0] care;
      slen = patcher.clip_len(patcher.search_len);
      for (int i = 0; i < len; i++) bytes = {bytes, 8'($urandom)};
      if (planted && slen > 0) begin
         for (int p = 0; p < len; p++) begin
            if ($urandom_range(99) < 30) begin
               for (int k = 0; k < slen && p + k < len; k++) begin
                  care = patcher.search_care[8*k +: 8];
                  bytes[p+k] = (patcher.search_value[8*k +: 8] & care) |
                               (8'($urandom) & ~care);
               end
            end
         end
      end
      return bytes;
   endfunction

   initial begin : stimulus
      byte_queue_type bytes;
      int unsigned phase_start;
      int unsigned len;
      int unsigned phase;

      repeat (3) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;
      @(negedge clock);

      // Reset settings: empty pattern, nothing may match.
      send_stream('{8'h00, 8'hFF});
      drain();

      // Two-byte pattern with a wildcard high nibble; the patch turns the
      // second candidate into a non-match and is cut short at stream end.
      write_all(64'h5DAB, 64'h0FFF, 4'd2, 64'h563412, 64'h0FF0FF, 4'd3, 1'b0);
      send_stream('{8'hAB, 8'h3D, 8'hAB, 8'hED, 8'h00, 8'h11, 8'h22, 8'h33,
                    8'h44, 8'hAB, 8'h7D});
      send_stream('{8'hAB});
      drain();

      // Over-long lengths saturate, all-wildcard pattern, first match only.
      write_all('1, '0, 4'd15, '1, '1, 4'd15, 1'b1);
      send_stream('{8'h01, 8'h02, 8'h03, 8'h04, 8'h05, 8'h06, 8'h07, 8'h08,
                    8'h09, 8'h0A});
      drain();

      phase = 0;
      while (items_sent < RANDOM_ITEMS + 24) begin
         case (phase % 4)
            0: begin send_gap_pct = 0;  stall_pct = 0;  end
            1: begin send_gap_pct = 62; stall_pct = 0;  end
            2: begin send_gap_pct = 0;  stall_pct = 62; end
            default: begin send_gap_pct = 22; stall_pct = 22; end
         endcase
         write_all(random_word(), random_mask(), random_len(),
                   random_word(), random_mask(), random_len(), 1'($urandom));
         phase_start = items_sent;
         while (items_sent - phase_start < 60) begin
            len = ($urandom_range(99) < 80) ? $urandom_range(1, 16) : $urandom_range(17, 40);
            bytes = make_stream(len, $urandom_range(99) < 75);
            send_stream(bytes);
         end
         drain();
         phase++;
      end

      $display("Sent %0d bytes in %0d streams under %0d register settings;",
               items_sent, streams_sent, settings_used);
      $display("checked %0d emitted bytes, %0d of them flagged as matches.",
               patcher.checked, patcher.hit_count);
      if (patcher.errors == 0) begin
         $display("nibble_wildcard_search_replace_core_tb: clean");
      end else begin
         $display("%0d mismatches", patcher.errors);
         $display("nibble_wildcard_search_replace_core_tb: errors");
      end
      $finish;
   end
endmodule

>>> nibble_wildcard_search_replace_core.f
rtl/core/nwsr_pkg.sv
rtl/core/nwsr_emit.sv
rtl/core/nibble_wildcard_search_replace_core.sv
bench/nibble_wildcard_search_replace_core_tb.sv
